FILE: design/frame_scoped_chained_hash_registry_defines.svh
// Assertion macros used by the checker file.
`ifndef FRAME_SCOPED_CHAINED_HASH_REGISTRY_DEFINES_SVH
`define FRAME_SCOPED_CHAINED_HASH_REGISTRY_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FSCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FSCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/fsch_pkg.sv
package fsch_pkg;

  // Default sizes
  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_NUM_BUCKETS = 256;
  localparam int DEF_MAX_FRAMES  = 64;

  // Request kinds
  localparam logic [1:0] REQ_REG  = 2'd0;
  localparam logic [1:0] REQ_FIND = 2'd1;
  localparam logic [1:0] REQ_PUSH = 2'd2;
  localparam logic [1:0] REQ_POP  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_ENTRY_FULL = 3'd2;
  localparam logic [2:0] ST_NO_FRAME   = 3'd3;
  localparam logic [2:0] ST_BAD_POP    = 3'd4;
  localparam logic [2:0] ST_FRAME_FULL = 3'd5;

  // Remainder unit: reciprocal multiply, then multiply back and correct
  localparam int MOD_STEPS = 2;

  // Datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR    = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd2;
  localparam logic [OP_W-1:0] OP_MOD_REQ  = 5'd3;
  localparam logic [OP_W-1:0] OP_MOD_RD   = 5'd4;
  localparam logic [OP_W-1:0] OP_MOD_STEP = 5'd5;
  localparam logic [OP_W-1:0] OP_HEAD_RD  = 5'd6;
  localparam logic [OP_W-1:0] OP_REG_WR   = 5'd7;
  localparam logic [OP_W-1:0] OP_CUR_HEAD = 5'd8;
  localparam logic [OP_W-1:0] OP_CUR_LINK = 5'd9;
  localparam logic [OP_W-1:0] OP_FOUND    = 5'd10;
  localparam logic [OP_W-1:0] OP_PUSH     = 5'd11;
  localparam logic [OP_W-1:0] OP_WM_RD    = 5'd12;
  localparam logic [OP_W-1:0] OP_WM_LATCH = 5'd13;
  localparam logic [OP_W-1:0] OP_POP_STEP = 5'd14;
  localparam logic [OP_W-1:0] OP_UNLINK   = 5'd15;
  localparam logic [OP_W-1:0] OP_POP_END  = 5'd16;
  localparam logic [OP_W-1:0] OP_FINISH   = 5'd17;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key_hash;
    logic [5:0]  frame_sel;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  entry_id;
    logic [5:0]  frame_num;
    logic [10:0] entry_total;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [2:0]      status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       clear_last;
    logic       no_frame;
    logic       entries_full;
    logic       frames_full;
    logic       bad_pop;
    logic       mod_last;
    logic       cur_end;
    logic       hash_hit;
    logic       pop_more;
  } flags_t;

endpackage

FILE: design/fsch_ctrl.sv
module fsch_ctrl import fsch_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  flags_t flags,
  output cmd_t   cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_MOD     = 4'd3;
  localparam logic [3:0] S_HEAD    = 4'd4;
  localparam logic [3:0] S_R_WR    = 4'd5;
  localparam logic [3:0] S_F_PTR   = 4'd6;
  localparam logic [3:0] S_F_CHK   = 4'd7;
  localparam logic [3:0] S_P_WM    = 4'd8;
  localparam logic [3:0] S_P_LOOP  = 4'd9;
  localparam logic [3:0] S_P_MODST = 4'd10;
  localparam logic [3:0] S_P_MOD   = 4'd11;
  localparam logic [3:0] S_P_UNL   = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state, state_next;
  logic [2:0] status_q, status_next;

  // Advance state and hold the pending status
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      status_q <= ST_OK;
    end else begin
      state    <= state_next;
      status_q <= status_next;
    end
  end

  // Sequence the datapath
  always_comb begin
    state_next  = state;
    status_next = status_q;
    cmd.op      = OP_NONE;
    cmd.status  = status_q;
    busy        = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (flags.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        status_next = ST_OK;
        unique case (flags.req_type)
          REQ_REG: begin
            if (flags.no_frame) begin
              status_next = ST_NO_FRAME;
              state_next  = S_DONE;
            end else if (flags.entries_full) begin
              status_next = ST_ENTRY_FULL;
              state_next  = S_DONE;
            end else begin
              cmd.op     = OP_MOD_REQ;
              state_next = S_MOD;
            end
          end
          REQ_FIND: begin
            cmd.op     = OP_MOD_REQ;
            state_next = S_MOD;
          end
          REQ_PUSH: begin
            if (flags.frames_full) status_next = ST_FRAME_FULL;
            else cmd.op = OP_PUSH;
            state_next = S_DONE;
          end
          default: begin
            if (flags.bad_pop) begin
              status_next = ST_BAD_POP;
              state_next  = S_DONE;
            end else begin
              cmd.op     = OP_WM_RD;
              state_next = S_P_WM;
            end
          end
        endcase
      end
      S_MOD: begin
        cmd.op = OP_MOD_STEP;
        if (flags.mod_last) state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.op     = OP_HEAD_RD;
        state_next = (flags.req_type == REQ_REG) ? S_R_WR : S_F_PTR;
      end
      S_R_WR: begin
        cmd.op     = OP_REG_WR;
        state_next = S_DONE;
      end
      S_F_PTR: begin
        cmd.op     = OP_CUR_HEAD;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (flags.cur_end) begin
          status_next = ST_NOT_FOUND;
          state_next  = S_DONE;
        end else if (flags.hash_hit) begin
          cmd.op     = OP_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.op = OP_CUR_LINK;
        end
      end
      S_P_WM: begin
        cmd.op     = OP_WM_LATCH;
        state_next = S_P_LOOP;
      end
      S_P_LOOP: begin
        if (flags.pop_more) begin
          cmd.op     = OP_POP_STEP;
          state_next = S_P_MODST;
        end else begin
          cmd.op     = OP_POP_END;
          state_next = S_DONE;
        end
      end
      S_P_MODST: begin
        cmd.op     = OP_MOD_RD;
        state_next = S_P_MOD;
      end
      S_P_MOD: begin
        cmd.op = OP_MOD_STEP;
        if (flags.mod_last) state_next = S_P_UNL;
      end
      S_P_UNL: begin
        cmd.op     = OP_UNLINK;
        state_next = S_P_LOOP;
      end
      S_DONE: begin
        cmd.op     = OP_FINISH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/fsch_dp.sv
module fsch_dp import fsch_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  cmd_t     cmd,
  output flags_t   flags,
  output logic     done,
  output result_t  result
);

  localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W    = $clog2(MAX_ENTRIES);
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int REM_W   = BKT_W + 1;
  localparam int FT_W    = $clog2(MAX_FRAMES + 1);
  localparam int FI_W    = $clog2(MAX_FRAMES);
  localparam int MC_W    = $clog2(MOD_STEPS);
  localparam int RCP_SH  = 32 + BKT_W;
  localparam logic [32:0] RECIP = 33'((64'd1 << RCP_SH) / 64'(NUM_BUCKETS));
  localparam logic [ENTRY_W-1:0] EMPTY = {ENTRY_W{1'b1}};
  localparam logic [REM_W-1:0]   NB    = REM_W'(NUM_BUCKETS);

  // Stores
  logic [ENTRY_W-1:0] head_mem [NUM_BUCKETS];
  logic [31:0]        hash_mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] link_mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] wm_mem   [MAX_FRAMES];

  logic [ENTRY_W-1:0] head_rd, link_rd, wm_rd;
  logic [31:0]        hash_rd;

  request_t           req_q;
  logic [BKT_W-1:0]   clr;
  logic [ENTRY_W-1:0] count, cur, idx, wm, id_q;
  logic [FT_W-1:0]    frame_total;
  logic [5:0]         fnum_q;
  logic [REM_W-1:0]   rem, rem_next, rem_est, qlow;
  logic [31:0]        mod_hash;
  logic [64:0]        recip_prod;
  logic [2*REM_W-1:0] back_prod;
  logic [MC_W-1:0]    mcnt;
  logic [BKT_W-1:0]   slot;
  logic [ID_W-1:0]    ent_addr;
  logic [FI_W-1:0]    sel_idx;
  logic [ENTRY_W-1:0] idx_dec;

  assign slot    = rem[BKT_W-1:0];
  assign sel_idx = FI_W'(req_q.frame_sel);
  assign idx_dec = idx - 1'b1;

  // Estimate the quotient low bits by reciprocal multiply (low by at most one)
  assign recip_prod = 65'(mod_hash) * 65'(RECIP);

  // Multiply back, subtract, and correct the remainder once
  always_comb begin
    back_prod = qlow * NB;
    rem_est   = mod_hash[REM_W-1:0] - back_prod[REM_W-1:0];
    rem_next  = (rem_est >= NB) ? rem_est - NB : rem_est;
  end

  // Pick the entry store read address
  always_comb begin
    case (cmd.op)
      OP_CUR_HEAD: ent_addr = head_rd[ID_W-1:0];
      OP_CUR_LINK: ent_addr = link_rd[ID_W-1:0];
      default:     ent_addr = idx_dec[ID_W-1:0];
    endcase
  end

  // Bucket heads: clear, prepend, unlink
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) head_mem[clr] <= EMPTY;
    else if (cmd.op == OP_REG_WR) head_mem[slot] <= count;
    else if (cmd.op == OP_UNLINK) head_mem[slot] <= link_rd;
    if (cmd.op == OP_HEAD_RD) head_rd <= head_mem[slot];
  end

  // Entry hash and link stores
  always_ff @(posedge clk) begin
    if (cmd.op == OP_REG_WR) begin
      hash_mem[count[ID_W-1:0]] <= req_q.key_hash;
      link_mem[count[ID_W-1:0]] <= head_rd;
    end
    if (cmd.op == OP_CUR_HEAD || cmd.op == OP_CUR_LINK || cmd.op == OP_POP_STEP) begin
      hash_rd <= hash_mem[ent_addr];
      link_rd <= link_mem[ent_addr];
    end
  end

  // Frame watermarks
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) wm_mem[FI_W'(frame_total)] <= count;
    if (cmd.op == OP_WM_RD) wm_rd <= wm_mem[sel_idx];
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr         <= '0;
      count       <= '0;
      frame_total <= FT_W'(1);
      done        <= 1'b0;
    end else begin
      done <= (cmd.op == OP_FINISH);
      if (cmd.op == OP_CLEAR) clr <= clr + 1'b1;
      if (cmd.op == OP_REG_WR) count <= count + 1'b1;
      if (cmd.op == OP_PUSH) frame_total <= frame_total + 1'b1;
      if (cmd.op == OP_POP_END) begin
        if (wm < count) count <= wm;
        frame_total <= frame_total - 1'b1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_q  <= request;
        id_q   <= '0;
        fnum_q <= 6'(frame_total - 1'b1);
      end
      OP_MOD_REQ, OP_MOD_RD: begin
        mod_hash <= (cmd.op == OP_MOD_REQ) ? req_q.key_hash : hash_rd;
        mcnt     <= '0;
      end
      OP_MOD_STEP: begin
        if (mcnt == '0) qlow <= recip_prod[RCP_SH +: REM_W];
        else rem <= rem_next;
        mcnt <= mcnt + 1'b1;
      end
      OP_REG_WR:   id_q   <= count;
      OP_CUR_HEAD: cur    <= head_rd;
      OP_CUR_LINK: cur    <= link_rd;
      OP_FOUND:    id_q   <= cur;
      OP_PUSH:     fnum_q <= 6'(frame_total);
      OP_WM_LATCH: begin
        wm  <= wm_rd;
        idx <= count;
      end
      OP_POP_STEP: idx    <= idx_dec;
      OP_POP_END:  fnum_q <= req_q.frame_sel;
      OP_FINISH: begin
        result.status      <= cmd.status;
        result.entry_id    <= 10'(id_q);
        result.frame_num   <= fnum_q;
        result.entry_total <= 11'(count);
      end
      default: ;
    endcase
  end

  // Status towards the controller
  always_comb begin
    flags.req_type     = req_q.req_type;
    flags.clear_last   = (clr == BKT_W'(NUM_BUCKETS - 1));
    flags.no_frame     = (frame_total <= FT_W'(1));
    flags.entries_full = (32'(count) >= 32'(MAX_ENTRIES));
    flags.frames_full  = (32'(frame_total) >= 32'(MAX_FRAMES));
    flags.bad_pop      = (req_q.frame_sel == 6'd0) ||
                         (32'(req_q.frame_sel) != 32'(frame_total) - 32'd1) ||
                         (32'(req_q.frame_sel) >= 32'(MAX_FRAMES));
    flags.mod_last     = (mcnt == MC_W'(MOD_STEPS - 1));
    flags.cur_end      = (32'(cur) >= 32'(MAX_ENTRIES));
    flags.hash_hit     = (hash_rd == req_q.key_hash);
    flags.pop_more     = (idx > wm);
  end

endmodule

FILE: design/frame_scoped_chained_hash_registry.sv
// Registry of 32-bit name hashes held in chained buckets, ids grouped in frames.
// Request side: drive request and raise start; the request is taken at an edge
// with start high and busy low. busy stays high until the work is done.
// Result side: done is high for one cycle with result valid; it cannot be held
// off, so the receiver must take it on that cycle.
// Request time depends on its kind and is set by the reciprocal bucket remainder
// unit and the single-port chain stores; a find takes longer for each chain entry
// passed without a match, and a pop for each entry it unlinks.
// A new request may be taken on the cycle done is shown.
// Reset: the control state and counters clear; the bucket heads are then swept to
// empty, one per cycle, with busy high before the first request.
module frame_scoped_chained_hash_registry import fsch_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  cmd_t   cmd;
  flags_t flags;

  // Sequencer
  fsch_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  // Stores and arithmetic
  fsch_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NUM_BUCKETS (NUM_BUCKETS),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .flags   (flags),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: design/fsch_checker.sv
`include "frame_scoped_chained_hash_registry_defines.svh"

module fsch_checker import fsch_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input request_t request,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  `FSCH_ASSERT(a_busy_after_take, (start && !busy) |=> busy, "busy low after request taken")
  `FSCH_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `FSCH_ASSERT_ALWAYS(a_status_known, done |-> (result.status <= ST_FRAME_FULL), "bad status")
  `FSCH_ASSERT(a_miss_zero_id, (done && result.status == ST_NOT_FOUND) |-> (result.entry_id == 10'd0), "miss with id")

endmodule

bind frame_scoped_chained_hash_registry fsch_checker u_chk (.*);
